// ----- hdl/cba_pkg.sv -----
// Shared types and constants for the cluster bitmap allocator.
// Used by every file in hdl/ except cba_ram; depends on nothing.
`default_nettype none
package cba_pkg;

  localparam int MAP_BITS     = 65536;
  localparam int WORD_BITS    = 64;
  localparam int MAP_WORDS    = MAP_BITS / WORD_BITS;
  localparam int CL_W         = 17;                        // cluster / count fields
  localparam int IDX_W        = $clog2(MAP_BITS);          // bit index in the map
  localparam int BI_W         = $clog2(WORD_BITS);         // bit within a word
  localparam int WA_W         = $clog2(MAP_WORDS);         // word address
  localparam int CNT_W        = $clog2(WORD_BITS) + 1;     // 0..WORD_BITS

  localparam logic [CL_W-1:0] CLUSTER_CAP = CL_W'(MAP_BITS + 1);
  localparam logic [CL_W-1:0] FIRST_CL    = CL_W'(2);
  localparam logic [CL_W-1:0] CNT_SAT     = {CL_W{1'b1}};

  // register indexes on the config port
  localparam logic CFG_END_CL      = 1'b0;
  localparam logic CFG_SECTOR_LOG2 = 1'b1;

  typedef enum logic [2:0] {
    FN_CLAIM   = 3'd0,
    FN_RELEASE = 3'd1,
    FN_READ    = 3'd2,
    FN_FIND    = 3'd3,
    FN_SCAN    = 3'd4
  } func_t;

  typedef struct packed {
    logic [CL_W-1:0] end_cl;
    logic [3:0]      sector_log2;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [CL_W-1:0] cluster;
    logic [CL_W-1:0] count;
    logic [CL_W-1:0] end_cluster;
    logic [CL_W-1:0] min_count;
    logic [CL_W-1:0] max_count;
  } in_item_t;

  typedef struct packed {
    logic            status;
    logic            bit_value;
    logic [CL_W-1:0] run_length;
    logic [CL_W-1:0] first_cluster;
    logic [CL_W-1:0] free_clusters;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic clr_wr;
    logic fill_rd;
    logic fill_wr;
    logic ch_start;
    logic seg;
    logic ch_end;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_fill;
    logic go_walk;
    logic clr_last;
    logic fill_last;
    logic loop_ok;
    logic seg_done;
    logic brk;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/cba_in_if.sv -----
// Input channel: valid/ready handshake with the request fields.
// Depends on cba_pkg for field widths.
`default_nettype none
interface cba_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                func;
  logic [cba_pkg::CL_W-1:0]  cluster;
  logic [cba_pkg::CL_W-1:0]  count;
  logic [cba_pkg::CL_W-1:0]  end_cluster;
  logic [cba_pkg::CL_W-1:0]  min_count;
  logic [cba_pkg::CL_W-1:0]  max_count;

  modport source (output valid, func, cluster, count, end_cluster, min_count, max_count,
                  input ready);
  modport sink   (input valid, func, cluster, count, end_cluster, min_count, max_count,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/cba_out_if.sv -----
// Result channel: valid/ready handshake with the result fields.
// Depends on cba_pkg for field widths.
`default_nettype none
interface cba_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      bit_value;
  logic [cba_pkg::CL_W-1:0]  run_length;
  logic [cba_pkg::CL_W-1:0]  first_cluster;
  logic [cba_pkg::CL_W-1:0]  free_clusters;

  modport source (output valid, status, bit_value, run_length, first_cluster, free_clusters,
                  input ready);
  modport sink   (input valid, status, bit_value, run_length, first_cluster, free_clusters,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/cba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module cba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cba_ctrl.sv -----
// Sequencer for the allocator: steps clear, fill and run-walk phases.
// Depends on cba_pkg (cmd_t, sts_t).
`default_nettype none
module cba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  output      logic          out_valid,
  input  wire logic          out_ready,
  input  wire cba_pkg::sts_t sts,
  output      cba_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_FILL_RD, S_FILL_WR, S_CH_START, S_CH_SEG, S_CH_END
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_pend_r, fin_pend_nxt;   // result computed path waiting for output slot

  always_comb begin
    state_nxt     = state_r;
    fin_pend_nxt  = fin_pend_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_pend_r && (!out_valid_r || out_ready)) begin
      cmd.finish    = 1'b1;
      out_valid_nxt = 1'b1;
      fin_pend_nxt  = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !fin_pend_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.go_fill) state_nxt = S_FILL_RD;
        else if (sts.go_walk)     state_nxt = S_CH_START;
        else begin
          fin_pend_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          fin_pend_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_FILL_RD;
        end
      end
      S_CH_START: begin
        if (sts.loop_ok) begin
          cmd.ch_start = 1'b1;
          state_nxt    = S_CH_SEG;
        end else begin
          fin_pend_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CH_SEG: begin
        cmd.seg = 1'b1;
        if (sts.seg_done) state_nxt = S_CH_END;
      end
      S_CH_END: begin
        cmd.ch_end = 1'b1;
        if (sts.brk) begin
          fin_pend_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_CH_START;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      fin_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fin_pend_r  <= fin_pend_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE) && !fin_pend_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- hdl/cba_dp.sv -----
// Datapath: request registers, free count, run walker, fill masks, result register.
// Depends on cba_pkg; drives the bitmap RAM ports.
`default_nettype none
module cba_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cba_pkg::cfg_t                    cfg,
  input  wire cba_pkg::in_item_t                in_item,
  input  wire cba_pkg::cmd_t                    cmd,
  output      cba_pkg::sts_t                    sts,
  output      logic                             ram_we,
  output      logic [cba_pkg::WA_W-1:0]         ram_waddr,
  output      logic [cba_pkg::WORD_BITS-1:0]    ram_wdata,
  output      logic                             ram_re,
  output      logic [cba_pkg::WA_W-1:0]         ram_raddr,
  input  wire logic [cba_pkg::WORD_BITS-1:0]    ram_rdata,
  output      cba_pkg::out_item_t               out_item
);

  localparam int CL_W  = cba_pkg::CL_W;
  localparam int IDX_W = cba_pkg::IDX_W;
  localparam int BI_W  = cba_pkg::BI_W;
  localparam int WA_W  = cba_pkg::WA_W;
  localparam int WB    = cba_pkg::WORD_BITS;
  localparam int CNT_W = cba_pkg::CNT_W;

  // trailing ones of a word
  function automatic logic [CNT_W-1:0] tr_ones(input logic [WB-1:0] x);
    logic [CNT_W-1:0] n;
    n = CNT_W'(WB);
    for (int k = WB - 1; k >= 0; k--) begin
      if (!x[k]) n = CNT_W'(k);
    end
    return n;
  endfunction

  // request
  logic [2:0]      func_r;
  logic [CL_W-1:0] c_r, n_r, endp_r, minc_r, maxc_r;
  // state
  logic [CL_W-1:0] kf_r;
  logic [WA_W-1:0] w_r;
  // walker
  logic [CL_W-1:0]  cur_r, pos_r, stop_r, rlen_r;
  logic [IDX_W-1:0] i0_r;
  logic             v_r, first_r, st_r;
  // find / scan accumulators
  logic [CL_W-1:0] ff_r, fc_r, start_r, cnt_r, total_r, best_r, bests_r;
  cba_pkg::out_item_t out_r;

  logic is_claim, is_rel, is_read, is_find, is_scan;
  assign is_claim = func_r == cba_pkg::FN_CLAIM;
  assign is_rel   = func_r == cba_pkg::FN_RELEASE;
  assign is_read  = func_r == cba_pkg::FN_READ;
  assign is_find  = func_r == cba_pkg::FN_FIND;
  assign is_scan  = func_r == cba_pkg::FN_SCAN;

  logic [CL_W-1:0] lim;
  assign lim = (cfg.end_cl > cba_pkg::CLUSTER_CAP) ? cba_pkg::CLUSTER_CAP
                                                   : cfg.end_cl;

  // range checks and fill bounds
  logic [CL_W:0]    sum_cn, hi_full;
  logic [CL_W-1:0]  lo_full;
  logic [IDX_W-1:0] lo_idx, hi_idx;
  logic             in_rng, rd_ok;
  assign sum_cn  = {1'b0, c_r} + {1'b0, n_r};
  assign in_rng  = (c_r >= cba_pkg::FIRST_CL) && (sum_cn <= ({1'b0, lim} + (CL_W+1)'(1)));
  assign rd_ok   = (c_r >= cba_pkg::FIRST_CL) && (c_r <= lim);
  assign lo_full = c_r - cba_pkg::FIRST_CL;
  assign hi_full = sum_cn - (CL_W+1)'(3);
  assign lo_idx  = lo_full[IDX_W-1:0];
  assign hi_idx  = hi_full[IDX_W-1:0];

  logic [CL_W-1:0] kf_sub, kf_add;
  logic [CL_W:0]   kf_add_w;
  assign kf_sub   = (kf_r >= n_r) ? (kf_r - n_r) : '0;
  assign kf_add_w = {1'b0, kf_r} + {1'b0, n_r};
  assign kf_add   = kf_add_w[CL_W] ? cba_pkg::CNT_SAT : kf_add_w[CL_W-1:0];

  // fill mask
  logic [WB-1:0] m_lo, m_hi, fmask, fill_word;
  assign m_lo      = (w_r == lo_idx[IDX_W-1:BI_W]) ? ({WB{1'b1}} << lo_idx[BI_W-1:0])
                                                   : {WB{1'b1}};
  assign m_hi      = (w_r == hi_idx[IDX_W-1:BI_W])
                     ? ({WB{1'b1}} >> (BI_W'(WB - 1) - hi_idx[BI_W-1:0])) : {WB{1'b1}};
  assign fmask     = m_lo & m_hi;
  assign fill_word = is_claim ? (ram_rdata | fmask) : (ram_rdata & ~fmask);

  // chunk start: sector end and limit bound the run
  logic [CL_W-1:0]  cur_i, lm1, ch_stop;
  logic [IDX_W-1:0] i16;
  logic [CL_W+1:0]  smask, send;
  assign cur_i   = cur_r - cba_pkg::FIRST_CL;
  assign i16     = cur_i[IDX_W-1:0];
  assign smask   = ((CL_W+2)'(1) << (5'd3 + {1'b0, cfg.sector_log2})) - (CL_W+2)'(1);
  assign send    = ({2'b0, cur_i} | smask) + (CL_W+2)'(1);
  assign lm1     = lim - CL_W'(1);
  assign ch_stop = (send > {2'b0, lm1}) ? lm1 : send[CL_W-1:0];

  // segment step within one word
  logic [BI_W-1:0]  bp;
  logic             vv;
  logic [WB-1:0]    sh;
  logic [CNT_W-1:0] eq, room;
  logic [CL_W-1:0]  rem, seg, newpos;
  logic             seg_done;
  assign bp       = pos_r[BI_W-1:0];
  assign vv       = first_r ? ram_rdata[bp] : v_r;
  assign sh       = (vv ? ram_rdata : ~ram_rdata) >> bp;
  assign eq       = tr_ones(sh);
  assign room     = CNT_W'(WB) - {1'b0, bp};
  assign rem      = stop_r - pos_r;
  assign seg      = (rem < CL_W'(eq)) ? rem : CL_W'(eq);
  assign newpos   = pos_r + seg;
  assign seg_done = (eq < room) || (newpos == stop_r);

  // find update at the end of a chunk
  logic [CL_W:0]   ffc;
  logic            cont, found, over;
  logic [CL_W-1:0] fcn, ffn, fcc, ff_f, fc_f;
  assign ffc   = {1'b0, ff_r} + {1'b0, fc_r};
  assign cont  = (ff_r != '0) && (ffc == {1'b0, cur_r});
  assign fcn   = cont ? (fc_r + rlen_r) : rlen_r;
  assign ffn   = cont ? ff_r : cur_r;
  assign found = fcn > minc_r;
  assign fcc   = (fcn > maxc_r) ? maxc_r : fcn;
  assign over  = ({1'b0, ffn} + {1'b0, fcc}) > ({1'b0, endp_r} + (CL_W+1)'(1));
  always_comb begin
    ff_f = ffn;
    fc_f = fcc;
    if (over) begin
      if (ffn > endp_r) ff_f = '0;
      else              fc_f = endp_r - ffn + CL_W'(1);
    end
  end

  // scan close-out
  logic [CL_W-1:0] tot_fin, bst_fin, bsts_fin;
  logic            open_run;
  assign open_run = start_r != '0;
  assign tot_fin  = open_run ? (total_r + cnt_r) : total_r;
  assign bst_fin  = (open_run && cnt_r > best_r) ? cnt_r : best_r;
  assign bsts_fin = (open_run && cnt_r > best_r) ? start_r : bests_r;

  // status
  always_comb begin
    sts           = '0;
    sts.go_fill   = (is_claim || is_rel) && in_rng && (n_r != '0);
    sts.go_walk   = (is_read && rd_ok) || is_find || is_scan;
    sts.clr_last  = w_r == WA_W'(cba_pkg::MAP_WORDS - 1);
    sts.fill_last = w_r == hi_idx[IDX_W-1:BI_W];
    sts.loop_ok   = is_read || (is_find && cur_r <= endp_r && cur_r <= lim)
                  || (is_scan && cur_r <= lim);
    sts.seg_done  = seg_done;
    sts.brk       = is_read || (is_find && !v_r && found);
  end

  // RAM ports
  always_comb begin
    ram_we    = cmd.clr_wr || cmd.fill_wr;
    ram_waddr = w_r;
    ram_wdata = cmd.fill_wr ? fill_word : '0;
    ram_re    = cmd.fill_rd || cmd.ch_start || (cmd.seg && !seg_done);
    priority if (cmd.fill_rd) ram_raddr = w_r;
    else if (cmd.ch_start)    ram_raddr = i16[IDX_W-1:BI_W];
    else                      ram_raddr = newpos[IDX_W-1:BI_W];
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kf_r <= '0;
      w_r  <= '0;
    end else begin
      if (cmd.clr_wr) w_r <= w_r + WA_W'(1);
      if (cmd.decode) begin
        w_r <= lo_idx[IDX_W-1:BI_W];
        if (is_claim && in_rng) kf_r <= kf_sub;
        if (is_rel && in_rng)   kf_r <= kf_add;
      end
      if (cmd.fill_wr) w_r <= w_r + WA_W'(1);
      if (cmd.finish && is_scan) kf_r <= tot_fin;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_item.func;
      c_r    <= in_item.cluster;
      n_r    <= in_item.count;
      endp_r <= in_item.end_cluster;
      minc_r <= in_item.min_count;
      maxc_r <= in_item.max_count;
    end
    if (cmd.decode) begin
      st_r    <= (is_rel && !in_rng) || (is_read && !rd_ok);
      cur_r   <= is_scan ? cba_pkg::FIRST_CL
               : (is_find && c_r < cba_pkg::FIRST_CL) ? cba_pkg::FIRST_CL : c_r;
      ff_r    <= '0;
      fc_r    <= '0;
      start_r <= '0;
      cnt_r   <= '0;
      total_r <= '0;
      best_r  <= '0;
      bests_r <= '0;
      rlen_r  <= '0;
      v_r     <= 1'b0;
    end
    if (cmd.ch_start) begin
      pos_r   <= {1'b0, i16};
      i0_r    <= i16;
      stop_r  <= ch_stop;
      first_r <= 1'b1;
    end
    if (cmd.seg) begin
      pos_r   <= newpos;
      v_r     <= vv;
      first_r <= 1'b0;
      if (seg_done) rlen_r <= newpos - {1'b0, i0_r};
    end
    if (cmd.ch_end) begin
      cur_r <= cur_r + rlen_r;
      if (is_find) begin
        if (v_r) begin
          ff_r <= '0;
          fc_r <= '0;
        end else if (found) begin
          ff_r <= ff_f;
          fc_r <= fc_f;
        end else begin
          ff_r <= ffn;
          fc_r <= fcn;
        end
      end
      if (is_scan) begin
        if (!v_r) begin
          if (!open_run) begin
            start_r <= cur_r;
            cnt_r   <= rlen_r;
          end else begin
            cnt_r <= cnt_r + rlen_r;
          end
        end else if (open_run) begin
          total_r <= total_r + cnt_r;
          if (cnt_r > best_r) begin
            best_r  <= cnt_r;
            bests_r <= start_r;
          end
          start_r <= '0;
        end
      end
    end
    if (cmd.finish) begin
      out_r.status        <= st_r;
      out_r.bit_value     <= is_read && !st_r && v_r;
      out_r.run_length    <= (is_read && !st_r) ? rlen_r
                           : is_find ? fc_r : is_scan ? bst_fin : '0;
      out_r.first_cluster <= is_find ? ff_r : is_scan ? bsts_fin : '0;
      out_r.free_clusters <= is_scan ? tot_fin : kf_r;
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- hdl/cluster_bitmap_allocator_unit.sv -----
// Top level of the cluster bitmap allocator: config registers, controller,
// datapath and bitmap RAM. Depends on cba_pkg, cba_in_if, cba_out_if, cba_ram,
// cba_ctrl and cba_dp.
//
//   port     dir   handshake          payload
//   in_if    sink  valid/ready        func, cluster, count, end_cluster, min/max_count
//   out_if   src   valid/ready        status, bit_value, run_length, first/free
//   cfg_*    in    cfg_we (no stall)  cfg_idx selects register, cfg_wdata value
//
// After reset a clearing pass writes all 1024 bitmap words to zero;
// in_if.ready stays low meanwhile, config writes are taken as ever.
// Claim/release read and rewrite each bitmap word touched. Read/find/scan walk
// runs through the single RAM read port, one run chunk at a time; a chunk that
// spans more than one word reads each of them in turn.
// One transaction is in flight; a finished result sits in the output register
// while the next transaction is accepted and decoded.
`default_nettype none
module cluster_bitmap_allocator_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  cba_in_if.sink                         in_if,
  cba_out_if.source                      out_if,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_idx,
  input  wire logic [cba_pkg::CL_W-1:0]  cfg_wdata
);

  cba_pkg::cfg_t      cfg_r;
  cba_pkg::cmd_t      cmd;
  cba_pkg::sts_t      sts;
  cba_pkg::in_item_t  in_item;
  cba_pkg::out_item_t out_item;

  logic                             ram_we, ram_re;
  logic [cba_pkg::WA_W-1:0]         ram_waddr, ram_raddr;
  logic [cba_pkg::WORD_BITS-1:0]    ram_wdata, ram_rdata;

  // config registers, writable at any time by contract only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_cl      <= cba_pkg::CLUSTER_CAP;
      cfg_r.sector_log2 <= 4'd9;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cba_pkg::CFG_END_CL:      cfg_r.end_cl      <= cfg_wdata;
        cba_pkg::CFG_SECTOR_LOG2: cfg_r.sector_log2 <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign in_item.func        = in_if.func;
  assign in_item.cluster     = in_if.cluster;
  assign in_item.count       = in_if.count;
  assign in_item.end_cluster = in_if.end_cluster;
  assign in_item.min_count   = in_if.min_count;
  assign in_item.max_count   = in_if.max_count;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_item  (out_item)
  );

  // one bit per cluster, bit 0 of word 0 is cluster 2
  cba_ram #(
    .WIDTH (cba_pkg::WORD_BITS),
    .DEPTH (cba_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_if.status        = out_item.status;
  assign out_if.bit_value     = out_item.bit_value;
  assign out_if.run_length    = out_item.run_length;
  assign out_if.first_cluster = out_item.first_cluster;
  assign out_if.free_clusters = out_item.free_clusters;

endmodule
`default_nettype wire
